[hdl/fplw_pkg.sv]
// Shared types and constants for the four-level page walker.
// Used by four_level_page_walker, page_walk_checker and testbench; depends on nothing else.

package fplw_pkg;

   localparam int PHYS_BITS = 52;
   localparam int ADDR_W    = 52;
   localparam int VA_W      = 48;
   localparam int ROOT_W    = 40;
   localparam int ENTRY_W   = 64;
   localparam int REQ_DW    = 152;
   localparam int RSP_DW    = 112;

   localparam logic [ADDR_W-1:0] PHYS_MASK =
      ADDR_W'((65'd1 << PHYS_BITS) - 65'd1);
   localparam logic [ADDR_W-1:0] OFF_4K = 52'h0_0000_0000_0FFF;
   localparam logic [ADDR_W-1:0] OFF_2M = 52'h0_0000_001F_FFFF;
   localparam logic [ADDR_W-1:0] OFF_1G = 52'h0_0000_3FFF_FFFF;
   localparam int PAGE_SHIFT = 12;

   localparam logic OP_START = 1'b0;
   localparam logic OP_ENTRY = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [1:0] SIZE_4K = 2'd0;
   localparam logic [1:0] SIZE_2M = 2'd1;
   localparam logic [1:0] SIZE_1G = 2'd2;

   localparam logic [1:0] LEVEL_PML4 = 2'd0;
   localparam logic [1:0] LEVEL_PDPT = 2'd1;
   localparam logic [1:0] LEVEL_PD   = 2'd2;
   localparam logic [1:0] LEVEL_PT   = 2'd3;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_LARGE   = 7;
   localparam int BIT_NX      = 63;

   typedef struct packed {
      logic              protocol_error;
      logic [1:0]        mapping_size;
      logic              executable;
      logic              mapped;
      logic [ADDR_W-1:0] physical_address;
      logic [ADDR_W-1:0] read_address;
      logic              result_kind;
   } result_type;

   localparam result_type RESULT_ERROR = '{
      protocol_error: 1'b1, mapping_size: SIZE_4K, executable: 1'b0, mapped: 1'b0,
      physical_address: '0, read_address: '0, result_kind: KIND_DONE};

endpackage

[hdl/four_level_page_walker.sv]
//  Channel  Dir  Handshake            tdata / tuser
//  req      in   req_tvalid/tready    VA, root frame, entry word / opcode
//  rsp      out  rsp_tvalid/tready    read addr, phys addr, flags, size / kind
//
//  One request per cycle unless rsp_tready holds the output; each result is registered in the
//  output register when its request is accepted.
//  req_tready stays high while the output register is empty or being drained.
//  Reset (synchronous) returns the walker to idle and empties the output register.
//
// Four-level x86-64 page table walker, top level. Depends on fplw_pkg.

module four_level_page_walker
   import fplw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // tdata: lookup_address[47:0], root_frame[87:48], entry_word[151:88]
   input  logic [REQ_DW-1:0] req_tdata,
   // tuser: opcode
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tdata: read_address[51:0], physical_address[103:52], mapped[104],
   // executable[105], mapping_size[107:106], protocol_error[108], zero pad[111:109]
   output logic [RSP_DW-1:0] rsp_tdata,
   // tuser: result_kind
   output logic              rsp_tuser
);

   logic [VA_W-1:0]    va;
   logic [ROOT_W-1:0]  root;
   logic [ENTRY_W-1:0] entry;
   logic               req_fire;

   logic              busy_ff, busy_in;
   logic [1:0]        level_ff, level_in;
   logic [VA_W-1:0]   held_ff, held_in;
   logic              exec_ff, exec_in;
   logic              valid_ff, valid_in;
   result_type        result_ff, result_in;

   logic [ADDR_W-1:0] base;
   logic              ex_path;
   logic              size_bit;

   assign va    = req_tdata[VA_W-1:0];
   assign root  = req_tdata[VA_W+ROOT_W-1:VA_W];
   assign entry = req_tdata[REQ_DW-1:VA_W+ROOT_W];

   assign req_tready = !valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign base     = entry[ADDR_W-1:0] & PHYS_MASK & ~OFF_4K;
   assign ex_path  = exec_ff && !entry[BIT_NX];
   assign size_bit = entry[BIT_LARGE];

   // Nine-bit table index of a virtual address, scaled to an entry offset.
   function automatic logic [ADDR_W-1:0] entry_offset(logic [VA_W-1:0] addr,
                                                      logic [1:0] lvl);
      logic [8:0] idx;
      unique case (lvl)
         LEVEL_PML4: idx = addr[47:39];
         LEVEL_PDPT: idx = addr[38:30];
         LEVEL_PD:   idx = addr[29:21];
         LEVEL_PT:   idx = addr[20:12];
         default:    idx = '0;
      endcase
      return ADDR_W'({idx, 3'b000});
   endfunction

   always_comb begin
      busy_in   = busy_ff;
      level_in  = level_ff;
      held_in   = held_ff;
      exec_in   = exec_ff;
      valid_in  = valid_ff;
      result_in = result_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (req_fire) begin
         valid_in  = 1'b1;
         result_in = '0;
         result_in.result_kind = KIND_DONE;
         if (req_tuser == OP_START) begin
            if (busy_ff) begin
               result_in = RESULT_ERROR;
            end else begin
               busy_in  = 1'b1;
               level_in = LEVEL_PML4;
               held_in  = va;
               exec_in  = 1'b1;
               result_in.result_kind  = KIND_READ;
               result_in.read_address =
                  (ADDR_W'({root, {PAGE_SHIFT{1'b0}}}) & PHYS_MASK)
                  | entry_offset(va, LEVEL_PML4);
            end
         end else if (!busy_ff) begin
            result_in = RESULT_ERROR;
         end else if (!entry[BIT_PRESENT]) begin
            // Not present: walk ends unmapped with every other field zero.
            busy_in  = 1'b0;
            level_in = LEVEL_PML4;
            exec_in  = 1'b1;
         end else if ((level_ff == LEVEL_PDPT && size_bit) || (level_ff == LEVEL_PD && size_bit)
                      || level_ff == LEVEL_PT) begin
            busy_in  = 1'b0;
            level_in = LEVEL_PML4;
            exec_in  = 1'b1;
            result_in.mapped     = 1'b1;
            result_in.executable = ex_path;
            if (level_ff == LEVEL_PDPT) begin
               result_in.mapping_size     = SIZE_1G;
               result_in.physical_address = (base & ~OFF_1G)
                  | (ADDR_W'(held_ff) & OFF_1G);
            end else if (level_ff == LEVEL_PD) begin
               result_in.mapping_size     = SIZE_2M;
               result_in.physical_address = (base & ~OFF_2M)
                  | (ADDR_W'(held_ff) & OFF_2M);
            end else begin
               result_in.mapping_size     = SIZE_4K;
               result_in.physical_address = base | (ADDR_W'(held_ff) & OFF_4K);
            end
         end else begin
            // Table pointer: descend one level. The page-size bit means nothing at the top.
            exec_in  = ex_path;
            level_in = level_ff + 2'd1;
            result_in.result_kind  = KIND_READ;
            result_in.read_address = base | entry_offset(held_ff, level_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         level_ff <= LEVEL_PML4;
         held_ff  <= '0;
         exec_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         level_ff <= level_in;
         held_ff  <= held_in;
         exec_ff  <= exec_in;
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = result_ff.result_kind;
   assign rsp_tdata  = RSP_DW'({result_ff.protocol_error, result_ff.mapping_size,
                                result_ff.executable, result_ff.mapped,
                                result_ff.physical_address, result_ff.read_address});

   // An idle walker always sits at the top level with a clean execute flag.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (level_ff == LEVEL_PML4 && exec_ff))
      else $error("idle walker holds stale level or execute state");

   // A read request never carries completion fields.
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && result_ff.result_kind == KIND_READ) |->
         (!result_ff.mapped && !result_ff.protocol_error && result_ff.physical_address == '0))
      else $error("read request carries completion fields");

   // Executable implies mapped.
   a_exec_mapped: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && result_ff.executable) |-> result_ff.mapped)
      else $error("executable result without a mapping");

   // A start accepted while idle leaves the walker busy and answers with a read.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == OP_START && !busy_ff) |=>
         (busy_ff && valid_ff && result_ff.result_kind == KIND_READ))
      else $error("accepted start did not begin a walk");

   // An error result leaves the walk state untouched.
   a_error_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ((req_tuser == OP_START && busy_ff) || (req_tuser == OP_ENTRY && !busy_ff)))
         |=> ($stable(busy_ff) && $stable(level_ff) && result_ff.protocol_error))
      else $error("out-of-sequence request disturbed the walk");

endmodule

[tb/page_walk_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the four-level page walker: watches both stream channels,
// predicts each result from the accepted requests and compares. Depends on fplw_pkg.

module page_walk_checker
   import fplw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,
   input  logic              req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_DW-1:0] rsp_tdata,
   input  logic              rsp_tuser,
   output int                failures,
   output int                outstanding,
   output int                results_checked
);

   // Walker state as the predictor sees it.
   logic              walk_busy;
   logic [1:0]        walk_level;
   logic [VA_W-1:0]   held_va;
   logic              exec_ok;

   result_type        expected_q[$];

   function automatic logic [8:0] table_index(input logic [VA_W-1:0] va,
                                              input logic [1:0] lvl);
      case (lvl)
         LEVEL_PML4: return va[47:39];
         LEVEL_PDPT: return va[38:30];
         LEVEL_PD:   return va[29:21];
         default:    return va[20:12];
      endcase
   endfunction

   task automatic end_walk();
      walk_busy  = 1'b0;
      walk_level = LEVEL_PML4;
      exec_ok    = 1'b1;
   endtask

   task automatic predict_walk(input logic op, input logic [VA_W-1:0] va,
                               input logic [ROOT_W-1:0] root,
                               input logic [ENTRY_W-1:0] entry,
                               output result_type r);
      logic [ADDR_W-1:0] frame;
      logic [ADDR_W-1:0] offset;
      logic [1:0]        size;
      logic              nx_clear;
      logic              is_leaf;
      r = '0;
      if (op == OP_START) begin
         if (walk_busy) begin
            // A second start is refused; the walk in flight carries on.
            r.result_kind    = KIND_DONE;
            r.protocol_error = 1'b1;
         end else begin
            held_va    = va;
            walk_busy  = 1'b1;
            walk_level = LEVEL_PML4;
            exec_ok    = 1'b1;
            r.result_kind  = KIND_READ;
            r.read_address = ((ADDR_W'(root) << PAGE_SHIFT) & PHYS_MASK)
                             | (ADDR_W'(table_index(va, LEVEL_PML4)) << 3);
         end
      end else if (!walk_busy) begin
         r.result_kind    = KIND_DONE;
         r.protocol_error = 1'b1;
      end else if (!entry[BIT_PRESENT]) begin
         end_walk();
         r.result_kind = KIND_DONE;
      end else begin
         nx_clear = exec_ok && !entry[BIT_NX];
         frame    = entry[ADDR_W-1:0] & PHYS_MASK & ~OFF_4K;
         is_leaf  = 1'b1;
         offset   = OFF_4K;
         size     = SIZE_4K;
         // The page-size bit only marks a leaf in directory-pointer and directory entries.
         if (walk_level == LEVEL_PDPT && entry[BIT_LARGE]) begin
            offset = OFF_1G;
            size   = SIZE_1G;
         end else if (walk_level == LEVEL_PD && entry[BIT_LARGE]) begin
            offset = OFF_2M;
            size   = SIZE_2M;
         end else if (walk_level != LEVEL_PT) begin
            is_leaf = 1'b0;
         end
         if (is_leaf) begin
            r.result_kind      = KIND_DONE;
            r.physical_address = (frame & ~offset) | (ADDR_W'(held_va) & offset);
            r.mapped           = 1'b1;
            r.executable       = nx_clear;
            r.mapping_size     = size;
            end_walk();
         end else begin
            exec_ok    = nx_clear;
            walk_level = walk_level + 2'd1;
            r.result_kind  = KIND_READ;
            r.read_address = frame | (ADDR_W'(table_index(held_va, walk_level)) << 3);
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [ADDR_W-1:0] want_v,
                                input logic [ADDR_W-1:0] got_v);
      if (got_v !== want_v) begin
         failures++;
         if (failures <= 10)
            $display("%0t: %s differs, expected %h, got %h", $realtime, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      result_type want;
      result_type got;
      if (reset) begin
         end_walk();
         held_va         = '0;
         expected_q.delete();
         failures        = 0;
         outstanding     = 0;
         results_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[108:0], rsp_tuser};
            results_checked++;
            if (expected_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: result arrived with none pending: %h", $realtime, got);
            end else begin
               want = expected_q.pop_front();
               compare_field("result_kind", ADDR_W'(want.result_kind),
                             ADDR_W'(got.result_kind));
               compare_field("read_address", want.read_address, got.read_address);
               compare_field("physical_address", want.physical_address,
                             got.physical_address);
               compare_field("mapped", ADDR_W'(want.mapped), ADDR_W'(got.mapped));
               compare_field("executable", ADDR_W'(want.executable),
                             ADDR_W'(got.executable));
               compare_field("mapping_size", ADDR_W'(want.mapping_size),
                             ADDR_W'(got.mapping_size));
               compare_field("protocol_error", ADDR_W'(want.protocol_error),
                             ADDR_W'(got.protocol_error));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_walk(req_tuser, req_tdata[47:0], req_tdata[87:48], req_tdata[151:88],
                         want);
            expected_q.push_back(want);
         end
         outstanding = expected_q.size();
      end
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Top of the page walker testbench: clock, reset and request stimulus,
// with page_walk_checker beside the walker. Depends on fplw_pkg.

module testbench;
   import fplw_pkg::*;

   localparam int RANDOM_ITEMS = 550;
   localparam int STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              rsp_tuser;

   int failures;
   int outstanding;
   int results_checked;
   int req_idle_pct = 24;
   int rsp_idle_pct = 24;
   int stall_requests = 0;
   int items_sent = 0;
   int walks_started = 0;
   int cycle_count = 0;

   four_level_page_walker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   page_walk_checker walk_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .failures        (failures),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                  outstanding);
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: random back-pressure, plus a long hold-off whenever one is requested.
   initial begin : result_sink
      int stalls_served;
      int hold_left;
      stalls_served = 0;
      hold_left     = 0;
      rsp_tready    = 1'b0;
      forever begin
         @(negedge clock);
         if (stalls_served < stall_requests) begin
            stalls_served++;
            hold_left = STALL_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [63:0] random_bits();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(input logic op, input logic [VA_W-1:0] va,
                               input logic [ROOT_W-1:0] root,
                               input logic [ENTRY_W-1:0] entry);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {entry, root, va};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == OP_START)
         walks_started++;
   endtask

   // One well-formed walk with random content. A stray start may be slipped in
   // partway down, which the walker must refuse without losing its place.
   task automatic run_walk(input bit stray_start);
      logic [63:0] word;
      bit          present;
      bit          leaf;
      int          lvl;
      send_request(OP_START, VA_W'(random_bits()), ROOT_W'(random_bits()), random_bits());
      for (lvl = LEVEL_PML4; lvl <= LEVEL_PT; lvl++) begin
         present = ($urandom_range(99) < 92);
         leaf    = (lvl == LEVEL_PDPT || lvl == LEVEL_PD) && ($urandom_range(2) == 0);
         word    = random_bits();
         word[BIT_PRESENT] = present;
         word[BIT_LARGE]   = (lvl == LEVEL_PDPT || lvl == LEVEL_PD) ? leaf
                                                                  : 1'($urandom_range(1));
         if (stray_start && lvl == LEVEL_PDPT)
            send_request(OP_START, VA_W'(random_bits()), ROOT_W'(random_bits()),
                         random_bits());
         send_request(OP_ENTRY, VA_W'(random_bits()), ROOT_W'(random_bits()), word);
         if (!present || leaf || lvl == LEVEL_PT)
            break;
      end
   endtask

   initial begin : stimulus
      int  first_random;
      int  n;
      int  pick;
      bit  stall_done;
      bit  pause_done;
      req_tvalid = 1'b0;
      req_tuser  = OP_START;
      req_tdata  = '0;
      stall_done = 1'b0;
      pause_done = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Out-of-sequence requests, extreme addresses and a walk through all-ones entries.
      send_request(OP_ENTRY, '1, '1, '1);
      send_request(OP_START, '1, '1, '1);
      send_request(OP_START, '0, '0, '0);
      send_request(OP_ENTRY, '0, '0, '1);
      send_request(OP_ENTRY, '0, '0, '1);
      // Executable 1 GiB page.
      send_request(OP_START, 48'h7A5_5C3D_2E1F, '0, '0);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_1001);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0001_4000_0081);
      // 2 MiB page with execute-disable on the leaf.
      send_request(OP_START, 48'h0123_4567_89AB, 40'h12_3456_789A, '0);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_1003);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_2003);
      send_request(OP_ENTRY, '0, '0, 64'h8000_000F_FFE0_0083);
      // 4 KiB page: page-size bit ignored in the page table, high frame bits masked.
      send_request(OP_START, 48'hFFFF_FFFF_F123, '0, '0);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_1001);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_2001);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_3001);
      send_request(OP_ENTRY, '0, '0, 64'h7FF0_0000_0000_5081);
      // Not present at the top level, then not present in the directory.
      send_request(OP_START, '1, '0, '0);
      send_request(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
      send_request(OP_START, '0, '1, '0);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_1001);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_2001);
      send_request(OP_ENTRY, '0, '0, 64'h0000_0000_0000_0000);

      first_random = items_sent;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         n = items_sent - first_random;
         if (n >= 150 && !stall_done) begin
            stall_requests++;
            stall_done = 1'b1;
         end
         if (n >= 250 && n < 340) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 24;
            rsp_idle_pct = 24;
         end
         if (n >= 420 && !pause_done) begin
            // Withdraw the request already taken so it is not offered again.
            @(negedge clock);
            req_tvalid <= 1'b0;
            wait (outstanding == 0);
            pause_done = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 72)
            run_walk(1'b0);
         else if (pick < 82)
            run_walk(1'b1);
         else
            send_request(1'($urandom_range(1)), VA_W'(random_bits()),
                         ROOT_W'(random_bits()), random_bits());
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests covering %0d walk starts; %0d results were checked.",
               items_sent, walks_started, results_checked);
      $display("Included a %0d-cycle output hold-off and a full drain pause.",
               STALL_CYCLES);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
